FILE: rtl/core/ugnb_pkg.sv
// shared types and constants for the uniform grid neighbor binning block
package ugnb_pkg;

    localparam int POS_W     = 16;          // signed Q11.4 position
    localparam int QUOT_W    = POS_W + 1;   // signed cell coordinate, holds -32768..32768
    localparam int CS_W      = 15;          // cell size register
    localparam int GRID_W    = 5;           // grid width / height registers
    localparam int IDX_W     = 10;          // agent index
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_NEIGHBOR = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_SKIPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 2'd2;

    // quotients of both coordinates, two's complement
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] qx;
        logic [QUOT_W-1:0] qy;
    } ugnb_div_res_t;

endpackage

FILE: rtl/core/uniform_grid_neighbor_binning.sv
// top level: uniform grid agent binning with 3x3 neighborhood queries
//
// Items come in on the s_ stream (tuser = opcode, tdata = agent fields and
// position) and results leave on the m_ stream (tuser = status, tdata =
// neighbor index, tlast marks the final result of an item). Geometry is set
// through the cfg_ write channel, which is always ready.
// One item is processed at a time; s_tready is high only while the block waits
// for a new item. An insert or a query first runs the 16-step shared divider
// for the cell coordinates; then an insert is skipped or reads its cell's
// count and, unless the cell is full, writes its entry, while a query visits
// each cell of its 3x3 neighborhood (one count memory read per in-grid cell),
// reads each entry found there and closes with a final result. The last found
// result is held back in a pending register so that its tlast can be set.
// Reset clears every cell (per-cell valid bits), sets the geometry to 16x16
// cells of size 16 and empties the output register. When the receiver stalls,
// the output register holds its item and the scan waits for it to drain.
module uniform_grid_neighbor_binning #(
    parameter int MAX_GRID_W   = 16,
    parameter int MAX_GRID_H   = 16,
    parameter int BUCKET_DEPTH = 4,
    parameter int MAX_AGENTS   = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // agent_index[9:0], active[10], x_position[26:11], y_position[42:27], zero fill
    input  logic [ugnb_pkg::S_TDATA_W-1:0]      s_tdata,
    // opcode[1:0]
    input  logic [ugnb_pkg::OP_W-1:0]           s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // neighbor_index[9:0], zero fill
    output logic [ugnb_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[2:0]
    output logic [ugnb_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ugnb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ugnb_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int NUM_CELLS = MAX_GRID_W * MAX_GRID_H;
    localparam int NUM_ENT   = NUM_CELLS * BUCKET_DEPTH;
    localparam int CELL_W    = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
    localparam int ENT_W     = NUM_ENT > 1 ? $clog2(NUM_ENT) : 1;
    localparam int SLOT_W    = BUCKET_DEPTH > 1 ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUCKET_DEPTH + 1);
    localparam int QW        = ugnb_pkg::QUOT_W;
    localparam int PW        = ugnb_pkg::POS_W;
    localparam int IW        = ugnb_pkg::IDX_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ONE  = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_CELL = 4'd3;
    localparam logic [3:0] ST_CNT  = 4'd4;
    localparam logic [3:0] ST_QENT = 4'd5;
    localparam logic [3:0] ST_QEND = 4'd6;

    logic [3:0]                   state_reg, state_next;
    logic [ugnb_pkg::OP_W-1:0]    op_reg, op_next;
    logic [IW-1:0]                agent_reg, agent_next;
    logic                         active_reg, active_next;
    logic [QW-1:0]                cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]                   dx_reg, dx_next, dy_reg, dy_next;
    logic [CELL_W-1:0]            cell_reg, cell_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic                         found_reg, found_next;
    logic [IW-1:0]                pend_reg, pend_next;
    logic [ugnb_pkg::STATUS_W-1:0] one_status_reg, one_status_next;
    logic [NUM_CELLS-1:0]         valid_reg, valid_next;

    logic                         m_valid_reg, m_valid_next;
    logic [ugnb_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IW-1:0]                m_idx_reg, m_idx_next;
    logic                         m_last_reg, m_last_next;

    logic [ugnb_pkg::GRID_W-1:0]  grid_w_reg, grid_h_reg;
    logic [ugnb_pkg::CS_W-1:0]    cell_size_reg;

    logic                         s_accept, out_free, out_load;
    logic                         div_start;
    ugnb_pkg::ugnb_div_res_t      div_res;

    logic [8:0]                   w9, h9, eff_w, eff_h;
    logic [QW:0]                  nx, ny;
    logic                         in_grid;
    logic [17:0]                  cell_full;
    logic [CELL_W-1:0]            cell_idx;
    logic                         agent_ok;
    logic                         adv_done;
    logic [1:0]                   dx_adv, dy_adv;

    logic                         cnt_re, cnt_we;
    logic [CNT_W-1:0]             cnt_rdata, cnt_eff, cnt_wdata;
    logic                         ent_re, ent_we;
    logic [ENT_W-1:0]             ent_base, ent_raddr, ent_waddr;
    logic [IW-1:0]                ent_rdata;
    logic [CNT_W:0]               slot_p1;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // effective geometry: zero reads as one, large values saturate
    assign w9    = {4'd0, grid_w_reg};
    assign h9    = {4'd0, grid_h_reg};
    assign eff_w = (w9 == 9'd0) ? 9'd1 : ((w9 > 9'(MAX_GRID_W)) ? 9'(MAX_GRID_W) : w9);
    assign eff_h = (h9 == 9'd0) ? 9'd1 : ((h9 > 9'(MAX_GRID_H)) ? 9'(MAX_GRID_H) : h9);

    // neighbor cell coordinate, offset codes 0..2 mean -1..+1
    assign nx = {cx_reg[QW-1], cx_reg} + {{(QW-1){1'b0}}, dx_reg} - (QW+1)'(1);
    assign ny = {cy_reg[QW-1], cy_reg} + {{(QW-1){1'b0}}, dy_reg} - (QW+1)'(1);
    assign in_grid = !nx[QW] && !ny[QW] &&
                     (nx < {{(QW-8){1'b0}}, eff_w}) && (ny < {{(QW-8){1'b0}}, eff_h});
    assign cell_full = ny[8:0] * eff_w + {9'd0, nx[8:0]};
    assign cell_idx  = cell_full[CELL_W-1:0];
    assign agent_ok  = ({7'd0, agent_reg} < 17'(MAX_AGENTS));

    assign adv_done = (dx_reg == 2'd2) && (dy_reg == 2'd2);
    assign dx_adv   = (dx_reg == 2'd2) ? 2'd0 : dx_reg + 2'd1;
    assign dy_adv   = (dx_reg == 2'd2) ? dy_reg + 2'd1 : dy_reg;

    assign cnt_eff   = valid_reg[cell_reg] ? cnt_rdata : '0;
    assign cnt_wdata = cnt_eff + CNT_W'(1);
    assign ent_base  = ENT_W'(cell_reg) * ENT_W'(BUCKET_DEPTH);
    assign slot_p1   = (CNT_W+1)'(slot_reg) + (CNT_W+1)'(1);
    assign ent_waddr = ent_base + ENT_W'(cnt_eff[SLOT_W-1:0]);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        agent_next      = agent_reg;
        active_next     = active_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        cell_next       = cell_reg;
        slot_next       = slot_reg;
        n_next          = n_reg;
        found_next      = found_reg;
        pend_next       = pend_reg;
        one_status_next = one_status_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_last_next     = m_last_reg;
        out_load        = 1'b0;
        div_start       = 1'b0;
        cnt_re          = 1'b0;
        cnt_we          = 1'b0;
        ent_re          = 1'b0;
        ent_we          = 1'b0;
        ent_raddr       = ent_base;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next     = s_tuser;
                    agent_next  = s_tdata[IW-1:0];
                    active_next = s_tdata[IW];
                    found_next  = 1'b0;
                    unique case (s_tuser)
                        ugnb_pkg::OP_CLEAR: begin
                            valid_next      = '0;
                            one_status_next = ugnb_pkg::STAT_CLEARED;
                            state_next      = ST_ONE;
                        end
                        ugnb_pkg::OP_INSERT: begin
                            div_start  = 1'b1;
                            dx_next    = 2'd1;
                            dy_next    = 2'd1;
                            state_next = ST_DIV;
                        end
                        ugnb_pkg::OP_QUERY: begin
                            div_start  = 1'b1;
                            dx_next    = 2'd0;
                            dy_next    = 2'd0;
                            state_next = ST_DIV;
                        end
                        default: begin
                            one_status_next = ugnb_pkg::STAT_SKIPPED;
                            state_next      = ST_ONE;
                        end
                    endcase
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_status_next = one_status_reg;
                    m_idx_next    = '0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    cx_next    = div_res.qx;
                    cy_next    = div_res.qy;
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                if (op_reg == ugnb_pkg::OP_INSERT) begin
                    if (!in_grid || !active_reg || !agent_ok) begin
                        one_status_next = ugnb_pkg::STAT_SKIPPED;
                        state_next      = ST_ONE;
                    end else begin
                        cell_next  = cell_idx;
                        cnt_re     = 1'b1;
                        state_next = ST_CNT;
                    end
                end else if (in_grid) begin
                    cell_next  = cell_idx;
                    cnt_re     = 1'b1;
                    state_next = ST_CNT;
                end else if (adv_done) begin
                    state_next = ST_QEND;
                end else begin
                    dx_next = dx_adv;
                    dy_next = dy_adv;
                end
            end
            ST_CNT: begin
                if (op_reg == ugnb_pkg::OP_INSERT) begin
                    if ((CNT_W+1)'(cnt_eff) >= (CNT_W+1)'(BUCKET_DEPTH)) begin
                        one_status_next = ugnb_pkg::STAT_FULL;
                    end else begin
                        cnt_we                = 1'b1;
                        ent_we                = 1'b1;
                        valid_next[cell_reg]  = 1'b1;
                        one_status_next       = ugnb_pkg::STAT_INSERTED;
                    end
                    state_next = ST_ONE;
                end else if (cnt_eff == '0) begin
                    if (adv_done) begin
                        state_next = ST_QEND;
                    end else begin
                        dx_next    = dx_adv;
                        dy_next    = dy_adv;
                        state_next = ST_CELL;
                    end
                end else begin
                    n_next     = cnt_eff;
                    slot_next  = '0;
                    ent_re     = 1'b1;
                    ent_raddr  = ent_base;
                    state_next = ST_QENT;
                end
            end
            ST_QENT: begin
                // previous find goes out with tlast low, this one is held back
                if (!found_reg || out_free) begin
                    if (found_reg) begin
                        out_load      = 1'b1;
                        m_valid_next  = 1'b1;
                        m_status_next = ugnb_pkg::STAT_NEIGHBOR;
                        m_idx_next    = pend_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_next  = ent_rdata;
                    found_next = 1'b1;
                    if (slot_p1 < (CNT_W+1)'(n_reg)) begin
                        slot_next = slot_p1[SLOT_W-1:0];
                        ent_re    = 1'b1;
                        ent_raddr = ent_base + ENT_W'(slot_p1);
                    end else if (adv_done) begin
                        state_next = ST_QEND;
                    end else begin
                        dx_next    = dx_adv;
                        dy_next    = dy_adv;
                        state_next = ST_CELL;
                    end
                end
            end
            ST_QEND: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_status_next = found_reg ? ugnb_pkg::STAT_NEIGHBOR : ugnb_pkg::STAT_EMPTY;
                    m_idx_next    = found_reg ? pend_reg : '0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            found_reg     <= 1'b0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
            grid_w_reg    <= ugnb_pkg::GRID_W'(16);
            grid_h_reg    <= ugnb_pkg::GRID_W'(16);
            cell_size_reg <= ugnb_pkg::CS_W'(16);
        end else begin
            state_reg   <= state_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ugnb_pkg::CFG_GRID_WIDTH:  grid_w_reg    <= cfg_data[ugnb_pkg::GRID_W-1:0];
                    ugnb_pkg::CFG_GRID_HEIGHT: grid_h_reg    <= cfg_data[ugnb_pkg::GRID_W-1:0];
                    ugnb_pkg::CFG_CELL_SIZE:   cell_size_reg <= cfg_data[ugnb_pkg::CS_W-1:0];
                    default: ;
                endcase
            end
        end
        op_reg         <= op_next;
        agent_reg      <= agent_next;
        active_reg     <= active_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        cell_reg       <= cell_next;
        slot_reg       <= slot_next;
        n_reg          <= n_next;
        pend_reg       <= pend_next;
        one_status_reg <= one_status_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_last_reg     <= m_last_next;
    end

    ugnb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .x_pos   (s_tdata[IW+1 +: PW]),
        .y_pos   (s_tdata[IW+1+PW +: PW]),
        .divisor (cell_size_reg),
        .res     (div_res)
    );

    ugnb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CELLS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cell_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cell_next),
        .rdata (cnt_rdata)
    );

    ugnb_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_ENT)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (agent_reg),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(ugnb_pkg::M_TDATA_W-IW){1'b0}}, m_idx_reg};

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register loaded while a stalled item is held");

    a_single_has_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ugnb_pkg::STAT_NEIGHBOR) |-> m_tlast)
        else $error("non-neighbor result without tlast");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_count_write_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (state_reg == ST_CNT && op_reg == ugnb_pkg::OP_INSERT && ent_we))
        else $error("count written outside an insert");

endmodule

FILE: rtl/core/ugnb_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module ugnb_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/ugnb_div.sv
// two-lane restoring divider: signed positions by cell size, truncating toward zero
module ugnb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ugnb_pkg::POS_W-1:0]    x_pos,
    input  logic [ugnb_pkg::POS_W-1:0]    y_pos,
    input  logic [ugnb_pkg::CS_W-1:0]     divisor,
    output ugnb_pkg::ugnb_div_res_t       res
);

    localparam int PW = ugnb_pkg::POS_W;
    localparam int CW = ugnb_pkg::CS_W;
    localparam int QW = ugnb_pkg::QUOT_W;

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [ugnb_pkg::STEP_W-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]                    numx_reg, numx_next, numy_reg, numy_next;
    logic [CW-1:0]                    remx_reg, remx_next, remy_reg, remy_next;
    logic                             negx_reg, negx_next, negy_reg, negy_next;
    logic [CW-1:0]                    div_reg, div_next;
    logic [QW-1:0]                    magx, magy;

    // one restoring step: returns {remainder, shifted numerator with new quotient bit}
    function automatic logic [CW+PW-1:0] div_step(input logic [CW-1:0] rem,
                                                  input logic [PW-1:0] num,
                                                  input logic [CW-1:0] d);
        logic [CW:0] sh;
        logic [CW:0] diff;
        logic        ge;
        sh   = {rem, num[PW-1]};
        diff = sh - {1'b0, d};
        ge   = (sh >= {1'b0, d});
        return {(ge ? diff[CW-1:0] : sh[CW-1:0]), num[PW-2:0], ge};
    endfunction

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        numx_next = numx_reg;
        numy_next = numy_reg;
        remx_next = remx_reg;
        remy_next = remy_reg;
        negx_next = negx_reg;
        negy_next = negy_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            negx_next = x_pos[PW-1];
            negy_next = y_pos[PW-1];
            numx_next = x_pos[PW-1] ? (~x_pos + PW'(1)) : x_pos;
            numy_next = y_pos[PW-1] ? (~y_pos + PW'(1)) : y_pos;
            remx_next = '0;
            remy_next = '0;
            div_next  = (divisor == '0) ? CW'(1) : divisor;
        end else if (busy_reg) begin
            {remx_next, numx_next} = div_step(remx_reg, numx_reg, div_reg);
            {remy_next, numy_next} = div_step(remy_reg, numy_reg, div_reg);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ugnb_pkg::STEP_W'(ugnb_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        div_reg  <= div_next;
    end

    assign magx     = {1'b0, numx_reg};
    assign magy     = {1'b0, numy_reg};
    assign res.done = done_reg;
    assign res.qx   = negx_reg ? (~magx + QW'(1)) : magx;
    assign res.qy   = negy_reg ? (~magy + QW'(1)) : magy;

endmodule
